// File: sv/esc_pkg.sv
// ============================================================================
// esc_pkg
// Shared types, constants and helpers of the environment-sensor compensation.
// ============================================================================
package esc_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        REG_TEMP     = 3'd0,
        REG_PRESS_LO = 3'd1,
        REG_PRESS_HI = 3'd2,
        REG_MIXED    = 3'd3,
        REG_HUMID    = 3'd4
    } reg_idx_t;

    // Temperature results and raw pressure and humidity handed from front to back.
    typedef struct packed {
        logic [31:0] t_fine;
        logic [31:0] temp;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
    } front_word_t;

    // Wrapping 32-bit product.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// File: sv/env_sensor_compensation.sv
// ============================================================================
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ============================================================================
// Usage:
//   s_valid/s_ready take one raw sample per word; m_valid/m_ready return
//   temperature (0.01 degC), pressure (Pa), humidity (%RH x 1024) and a
//   divide-by-zero flag. cfg_valid/cfg_ready write calibration register
//   cfg_index with cfg_data; write only while idle.
//   Throughput: one word per cycle sustained while the output is not held.
//   Pipeline from the accepting edge to m_valid: 3 front stages,
//   1 queue stage, 45 back stages (32 of them set by the divider pipeline,
//   one quotient bit per stage).
//   Reset clears calibration to zero and empties all pipelines.
//   When m_valid is held with m_ready low the back pipeline freezes; the
//   front keeps taking words until queue plus front stages reach the queue
//   depth, then s_ready drops.
// ============================================================================
module env_sensor_compensation import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [19:0] s_raw_temperature,
    input  logic [19:0] s_raw_pressure,
    input  logic [15:0] s_raw_humidity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_temperature_centi,
    output logic [31:0] m_pressure_pa,
    output logic [16:0] m_humidity_q10,
    output logic        m_pressure_div_zero,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    logic [47:0] temp_reg, mixed_reg;
    logic [63:0] plo_reg, phi_reg;
    logic [31:0] hum_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg <= '0; plo_reg <= '0; phi_reg <= '0;
            mixed_reg <= '0; hum_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TEMP:     temp_reg  <= cfg_data[47:0];
                REG_PRESS_LO: plo_reg   <= cfg_data;
                REG_PRESS_HI: phi_reg   <= cfg_data;
                REG_MIXED:    mixed_reg <= cfg_data[47:0];
                REG_HUMID:    hum_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // front: always runs; s_ready admits words only while the queue can absorb everything in flight
    logic        f_valid, q_ne, b_en, b_valid, pop;
    front_word_t f_word, q_head;
    logic [QAW:0] q_cnt;
    logic [QAW:0] occ;
    logic [31:0] b_temp, b_press;
    logic [16:0] b_hum;
    logic        b_dz;
    logic [2:0]  f_stages;

    // words in the queue plus words in the front never exceed the queue depth
    assign occ = q_cnt + (QAW+1)'(f_stages[0]) + (QAW+1)'(f_stages[1])
               + (QAW+1)'(f_stages[2]);
    assign s_ready = pop || (occ < (QAW+1)'(QDEPTH));

    esc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(1'b1),
        .in_valid(s_valid && s_ready),
        .raw_t(s_raw_temperature), .raw_p(s_raw_pressure), .raw_h(s_raw_humidity),
        .temp_calib(temp_reg), .out_valid(f_valid), .stage_valid(f_stages),
        .out_word(f_word)
    );

    // back stalls only when its output is held
    assign b_en = !m_valid || m_ready;
    assign pop  = q_ne && b_en;

    esc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(f_valid), .push_word(f_word),
        .pop(pop), .not_empty(q_ne), .head(q_head), .count(q_cnt)
    );

    esc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .en(b_en), .in_valid(pop), .in_word(q_head),
        .press_lo(plo_reg), .press_hi(phi_reg), .mixed(mixed_reg), .humid(hum_reg),
        .out_valid(b_valid), .o_temp(b_temp), .o_press(b_press), .o_hum(b_hum),
        .o_dz(b_dz)
    );

    assign m_valid             = b_valid;
    assign m_temperature_centi = $signed(b_temp);
    assign m_pressure_pa       = b_press;
    assign m_humidity_q10      = b_hum;
    assign m_pressure_div_zero = b_dz;
endmodule

// File: sv/esc_front.sv
// ============================================================================
// esc_front
// Input stage: temperature compensation and fine-temperature term, 3 stages.
// ============================================================================
module esc_front import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [19:0] raw_t,
    input  logic [19:0] raw_p,
    input  logic [15:0] raw_h,
    input  logic [47:0] temp_calib,
    output logic        out_valid,
    output logic [2:0]  stage_valid,
    output front_word_t out_word
);
    logic [31:0] t1, t2, t3;
    logic [31:0] rt, d;
    logic [2:0]  v_reg;
    logic [31:0] m1_reg, dd_reg;
    logic [31:0] v1_reg, m2_reg;
    logic [19:0] p0_reg, p1_reg, p2_reg;
    logic [15:0] h0_reg, h1_reg, h2_reg;
    logic [31:0] tf_reg, temp_reg, tf;

    assign t1 = {16'd0, temp_calib[15:0]};
    assign t2 = sx16(temp_calib[31:16]);
    assign t3 = sx16(temp_calib[47:32]);
    assign rt = {12'd0, raw_t};
    assign d  = (rt >> 4) - t1;
    assign tf = v1_reg + $unsigned($signed(m2_reg) >>> 14);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg   <= mul32((rt >> 3) - (t1 << 1), t2);
            dd_reg   <= mul32(d, d);
            p0_reg   <= raw_p;
            h0_reg   <= raw_h;
            v1_reg   <= $unsigned($signed(m1_reg) >>> 11);
            m2_reg   <= mul32($unsigned($signed(dd_reg) >>> 12), t3);
            p1_reg   <= p0_reg;
            h1_reg   <= h0_reg;
            tf_reg   <= tf;
            temp_reg <= $unsigned($signed(mul32(tf, 32'd5) + 32'd128) >>> 8);
            p2_reg   <= p1_reg;
            h2_reg   <= h1_reg;
        end
    end

    assign out_valid   = v_reg[2];
    assign stage_valid = v_reg;
    assign out_word  = '{t_fine: tf_reg, temp: temp_reg, raw_p: p2_reg, raw_h: h2_reg};
endmodule

// File: sv/esc_queue.sv
// ============================================================================
// esc_queue
// Short FIFO between front and back; stores words in flops.
// ============================================================================
module esc_queue import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  front_word_t push_word,
    input  logic        pop,
    output logic        not_empty,
    output front_word_t head,
    output logic [QAW:0] count
);
    front_word_t mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_word;
    end

    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rp_reg];
    assign count     = cnt_reg;
endmodule

// File: sv/esc_divider.sv
// ============================================================================
// esc_divider
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// ============================================================================
module esc_divider import esc_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);
    logic [31:0] r_reg [33];
    logic [31:0] q_reg [33];
    logic [31:0] d_reg [33];

    always_comb begin
        r_reg[0] = '0;
        q_reg[0] = num;
        d_reg[0] = den;
    end

    for (genvar i = 0; i < 32; i++) begin : g_st
        logic [32:0] r_sh, diff;
        assign r_sh = {r_reg[i], q_reg[i][31]};
        assign diff = r_sh - {1'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1] <= diff[32] ? r_sh[31:0] : diff[31:0];
                q_reg[i+1] <= {q_reg[i][30:0], ~diff[32]};
                d_reg[i+1] <= d_reg[i];
            end
        end
    end

    assign quo = q_reg[32];
endmodule

// File: sv/esc_back.sv
// ============================================================================
// esc_back
// Back pipeline: humidity and pressure from t_fine, with pipelined divide.
// ============================================================================
module esc_back import esc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  front_word_t in_word,
    input  logic [63:0] press_lo,
    input  logic [63:0] press_hi,
    input  logic [47:0] mixed,
    input  logic [31:0] humid,
    output logic        out_valid,
    output logic [31:0] o_temp,
    output logic [31:0] o_press,
    output logic [16:0] o_hum,
    output logic        o_dz
);
    localparam int NS = 45;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    assign p1 = {16'd0, press_lo[15:0]};
    assign p2 = sx16(press_lo[31:16]);
    assign p3 = sx16(press_lo[47:32]);
    assign p4 = sx16(press_lo[63:48]);
    assign p5 = sx16(press_hi[15:0]);
    assign p6 = sx16(press_hi[31:16]);
    assign p7 = sx16(press_hi[47:32]);
    assign p8 = sx16(press_hi[63:48]);
    assign p9 = sx16(mixed[15:0]);
    assign h1 = {24'd0, mixed[23:16]};
    assign h2 = sx16(mixed[39:24]);
    assign h3 = {24'd0, mixed[47:40]};
    assign h4 = {{20{humid[11]}}, humid[11:0]};
    assign h5 = {{20{humid[23]}}, humid[23:12]};
    assign h6 = {{24{humid[31]}}, humid[31:24]};

    logic [NS-1:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (en)  v_reg <= {v_reg[NS-2:0], in_valid};
    end
    assign out_valid = v_reg[NS-1];

    // temperature and humidity delay lines
    logic [31:0] temp_d [NS];
    logic [16:0] hum_d  [NS];
    // stage 1
    logic [31:0] s1_x, s1_a0, s1_m5, s1_b, s1_c, s1_pv1, s1_rp;
    // stage 2
    logic [31:0] s2_a, s2_b, s2_c, s2_pv1, s2_qq, s2_m5, s2_rp;
    // stage 3
    logic [31:0] s3_a, s3_be, s3_pv2a, s3_m3, s3_m2, s3_m5, s3_rp;
    // stage 4
    logic [31:0] s4_a, s4_e, s4_pv2, s4_pv1;
    logic [31:0] s4_rp;
    // stage 5
    logic [31:0] s5_a, s5_f, s5_pm1, s5_pv2, s5_rp;
    // stage 6
    logic [31:0] s6_x, s6_pv1, s6_num;
    // stage 7
    logic [31:0] s7_x, s7_gg, s7_pv1, s7_num;
    // stage 8
    logic [31:0] s8_x, s8_gh, s8_pv1, s8_pnum;
    logic [31:0] s9_pv1, s9_num;
    logic        s9_big;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x   <= in_word.t_fine - 32'd76800;
            s1_a0  <= ({16'd0, in_word.raw_h} << 14) - (h4 << 20) + 32'd16384;
            s1_m5  <= h5;
            s1_pv1 <= asr(in_word.t_fine, 1) - 32'd64000;
            s1_rp  <= {12'd0, in_word.raw_p};
            temp_d[0] <= in_word.temp;

            s2_a   <= asr(s1_a0 - mul32(s1_m5, s1_x), 15);
            s2_b   <= asr(mul32(s1_x, h6), 10);
            s2_c   <= asr(mul32(s1_x, h3), 11) + 32'd32768;
            s2_pv1 <= s1_pv1;
            s2_qq  <= mul32(asr(s1_pv1, 2), asr(s1_pv1, 2));
            s2_m5  <= mul32(s1_pv1, p5);
            s2_rp  <= s1_rp;
            temp_d[1] <= temp_d[0];

            s3_a    <= s2_a;
            s3_be   <= mul32(s2_b, s2_c);
            s3_pv2a <= mul32(asr(s2_qq, 11), p6);
            s3_m3   <= mul32(p3, asr(s2_qq, 13));
            s3_m2   <= mul32(p2, s2_pv1);
            s3_m5   <= s2_m5;
            s3_rp   <= s2_rp;
            temp_d[2] <= temp_d[1];

            s4_a   <= s3_a;
            s4_e   <= asr(s3_be, 10) + 32'd2097152;
            s4_pv2 <= asr(s3_pv2a + (s3_m5 << 1), 2) + (p4 << 16);
            s4_pv1 <= asr(asr(s3_m3, 3) + asr(s3_m2, 1), 18);
            s4_rp  <= s3_rp;
            temp_d[3] <= temp_d[2];

            s5_a   <= s4_a;
            s5_f   <= mul32(s4_e, h2);
            s5_pm1 <= mul32(32'd32768 + s4_pv1, p1);
            s5_pv2 <= s4_pv2;
            s5_rp  <= s4_rp;
            temp_d[4] <= temp_d[3];

            s6_x   <= mul32(s5_a, asr(s5_f + 32'd8192, 14));
            s6_pv1 <= asr(s5_pm1, 15);
            s6_num <= (32'd1048576 - s5_rp) - asr(s5_pv2, 12);
            temp_d[5] <= temp_d[4];

            s7_x   <= s6_x;
            s7_gg  <= mul32(asr(s6_x, 15), asr(s6_x, 15));
            s7_pv1 <= s6_pv1;
            s7_num <= mul32(s6_num, 32'd3125);
            temp_d[6] <= temp_d[5];

            s8_x    <= s7_x;
            s8_gh   <= mul32(asr(s7_gg, 7), h1);
            s8_pv1  <= s7_pv1;
            s8_pnum <= s7_num;
            temp_d[7] <= temp_d[6];

            s9_pv1 <= s8_pv1;
            s9_big <= s8_pnum[31];
            s9_num <= s8_pnum[31] ? s8_pnum : (s8_pnum << 1);
            begin
                logic [31:0] hx;
                hx = s8_x - asr(s8_gh, 4);
                if (hx[31])                    hum_d[8] <= '0;
                else if (hx > 32'd419430400)   hum_d[8] <= 17'(32'd419430400 >> 12);
                else                           hum_d[8] <= hx[28:12];
            end
            temp_d[8] <= temp_d[7];
        end
    end

    // divider: 32 stages after stage 9
    logic [31:0] quo;
    esc_divider u_div (.aclk(aclk), .en(en), .num(s9_num), .den(s9_pv1), .quo(quo));

    localparam int DL = 32;
    logic [DL-1:0] big_d, dz_d;
    always_ff @(posedge aclk) begin
        if (en) begin
            big_d <= {big_d[DL-2:0], s9_big};
            dz_d  <= {dz_d[DL-2:0], s9_pv1 == '0};
        end
    end
    for (genvar k = 9; k < NS; k++) begin : g_dl
        always_ff @(posedge aclk) begin
            if (en) begin
                temp_d[k] <= temp_d[k-1];
                hum_d[k]  <= hum_d[k-1];
            end
        end
    end

    // post-divide correction through t0, t1, t2 and op_reg
    logic [31:0] t0_p, t1_p, t1_sq, t2_p, t2_v1, t2_v2;
    logic        t0_dz, t1_dz, t2_dz;
    logic [31:0] op_reg;
    logic        dz_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t0_p  <= big_d[DL-1] ? (quo << 1) : quo;
            t0_dz <= dz_d[DL-1];
            t1_p  <= t0_p;
            t1_sq <= mul32(t0_p >> 3, t0_p >> 3);
            t1_dz <= t0_dz;
            t2_p  <= t1_p;
            t2_v1 <= asr(mul32(p9, t1_sq >> 13), 12);
            t2_v2 <= asr(mul32(t1_p >> 2, p8), 13);
            t2_dz <= t1_dz;
            op_reg <= t2_dz ? '0 : t2_p + asr(t2_v1 + t2_v2 + p7, 4);
            dz_reg <= t2_dz;
        end
    end

    assign o_temp  = temp_d[NS-1];
    assign o_hum   = hum_d[NS-1];
    assign o_press = op_reg;
    assign o_dz    = dz_reg;
endmodule

// File: sv/esc_checker.sv
// ============================================================================
// esc_checker
// Port-level checks on the compensation block.
// ============================================================================
module esc_checker import esc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_pressure_pa,
    input logic [16:0] m_humidity_q10,
    input logic        m_pressure_div_zero
);
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_humidity_q10 <= 17'd102400) else $error("humidity out of range");
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pressure_div_zero |-> m_pressure_pa == '0) else $error("dz press");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure_pa))
        else $error("output not held");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid) else $error("reset");
endmodule

bind env_sensor_compensation esc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_pressure_pa(m_pressure_pa),
    .m_humidity_q10(m_humidity_q10), .m_pressure_div_zero(m_pressure_div_zero)
);
